// ===== hw/rtl/bba_pkg.sv =====
// Shared types, codes and constants of the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

   // Geometry of one free-map word.
   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;

   // Defaults for the top-level parameters.
   localparam int MAX_BLOCKS_DEFAULT = 256;
   localparam int MAP_WORDS_DEFAULT  = 8;
   localparam int REF_WIDTH_DEFAULT  = 8;

   // Fixed port field widths.
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   localparam logic [COUNT_W-1:0] POOL_SIZE_RESET = 9'd256;

   typedef enum logic [OP_W-1:0] {
      OP_INIT   = 2'd0,
      OP_ALLOC  = 2'd1,
      OP_FREE   = 2'd2,
      OP_RETAIN = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_INIT,
      S_SCAN,
      S_RMW
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // request taken this cycle
      logic clear_step;   // post-reset clearing sweep, one entry
      logic init_step;    // write one free-map word of the init fill
      logic init_done;    // last init word, answer the request
      logic scan_next;    // current map word empty, read the next one
      logic alloc_take;   // current map word has a free block, take it
      logic alloc_empty;  // no free block, answer pool empty
      logic bad_index;    // free or retain index out of range
      logic rmw_do;       // update count and map for free or retain
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;   // sweep counter at the last clearing entry
      logic init_last;    // sweep counter at the last map word
      logic hint_end;     // hint is past the last map word
      logic index_ok;     // requested block index is inside the pool
      logic word_zero;    // map word on the read port has no free block
      logic last_word;    // map word on the read port is the last one
   } dp_stat_type;

endpackage

// ===== hw/rtl/bitmap_block_allocator_unit.sv =====
// Top level of the bitmap block allocator: controller, datapath and checks.
`timescale 1ns / 1ps

// A fixed-size block pool kept as a free bitmap of 32-bit words, with a
// reference count per block and used and peak-used counters. A request is
// taken when start is high and busy is low; its single response appears on
// the rsp_ ports for exactly one cycle with rsp_valid high and cannot be
// held off, so capture it in that cycle. A free or retain does one
// read-modify-write of the count and map RAMs, and is answered without it
// when the index is out of range. An allocate scans map words from the
// hint and is answered without a scan when the hint is already past the
// last word. An init rewrites the map RAM one word per cycle. After reset
// the block stays busy while it clears every entry of both RAMs; pool_size
// writes are taken during that time, and csr_ready is low only while reset
// is applied.
module bitmap_block_allocator_unit #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT,
   parameter int MAP_WORDS  = bba_pkg::MAP_WORDS_DEFAULT,
   parameter int REF_WIDTH  = bba_pkg::REF_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          start,
   output logic                          busy,
   input  logic [bba_pkg::OP_W-1:0]      req_operation,
   input  logic [bba_pkg::INDEX_W-1:0]   req_block_index,
   // Configuration write channel for pool_size.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bba_pkg::COUNT_W-1:0]   csr_pool_size,
   // Response channel.
   output logic                          rsp_valid,
   output logic [bba_pkg::INDEX_W-1:0]   rsp_granted_index,
   output logic [bba_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bba_pkg::COUNT_W-1:0]   rsp_used_count,
   output logic [bba_pkg::COUNT_W-1:0]   rsp_peak_used
);

   import bba_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   status_type  status_code;

   // The register port is free whenever reset is not applied.
   assign csr_ready = !reset;

   // The controller sequences every request: clearing sweep, init fill,
   // word scan for an allocate and the read-modify-write of free or retain.
   bba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   // The datapath holds the map and count RAMs, the hint, the counters and
   // the response registers.
   bba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .MAP_WORDS  (MAP_WORDS),
      .REF_WIDTH  (REF_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_valid && csr_ready),
      .csr_pool_size     (csr_pool_size),
      .req_operation     (req_operation),
      .req_block_index   (req_block_index),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (status_code),
      .rsp_used_count    (rsp_used_count),
      .rsp_peak_used     (rsp_peak_used)
   );

   assign rsp_status = status_code;

   // A taken request is either answered at once or keeps the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   // At most one kind of response is issued in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.alloc_take, cmd.alloc_empty, cmd.bad_index,
                cmd.rmw_do, cmd.init_done}))
      else $error("more than one response command at once");

   // A request that fails leaves the used count as it was.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |->
         (rsp_used_count == $past(rsp_used_count)))
      else $error("failed request changed the used count");

   // An empty pool never hands out a block.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_EMPTY)) |-> (rsp_granted_index == '0))
      else $error("pool empty response with nonzero block index");

endmodule

// ===== hw/rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// Controller state machine of the bitmap block allocator.
`timescale 1ns / 1ps

module bba_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bba_pkg::OP_W-1:0]   req_operation,
   input  bba_pkg::dp_stat_type       stat,
   output bba_pkg::dp_cmd_type        cmd,
   output logic                       busy
);

   import bba_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start && !reset) begin
               cmd.accept = 1'b1;
               unique case (op_type'(req_operation))
                  OP_INIT: begin
                     state_in = S_INIT;
                  end
                  OP_ALLOC: begin
                     if (stat.hint_end) begin
                        cmd.alloc_empty = 1'b1;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE, OP_RETAIN: begin
                     if (!stat.index_ok) begin
                        cmd.bad_index = 1'b1;
                     end else begin
                        state_in = S_RMW;
                     end
                  end
               endcase
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_last) begin
               cmd.init_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            priority if (!stat.word_zero) begin
               cmd.alloc_take = 1'b1;
               state_in       = S_IDLE;
            end else if (stat.last_word) begin
               cmd.alloc_empty = 1'b1;
               state_in        = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_RMW: begin
            cmd.rmw_do = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign busy = reset || (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/bba_datapath.sv =====
// Datapath of the bitmap block allocator: free map, counts, hint and counters.
`timescale 1ns / 1ps

module bba_datapath #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT,
   parameter int MAP_WORDS  = bba_pkg::MAP_WORDS_DEFAULT,
   parameter int REF_WIDTH  = bba_pkg::REF_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bba_pkg::COUNT_W-1:0]   csr_pool_size,
   input  logic [bba_pkg::OP_W-1:0]      req_operation,
   input  logic [bba_pkg::INDEX_W-1:0]   req_block_index,
   input  bba_pkg::dp_cmd_type           cmd,
   output bba_pkg::dp_stat_type          stat,
   output logic                          rsp_valid,
   output logic [bba_pkg::INDEX_W-1:0]   rsp_granted_index,
   output bba_pkg::status_type           rsp_status,
   output logic [bba_pkg::COUNT_W-1:0]   rsp_used_count,
   output logic [bba_pkg::COUNT_W-1:0]   rsp_peak_used
);

   import bba_pkg::*;

   localparam int WA    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int HW    = $clog2(MAP_WORDS + 1);
   localparam int BA    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int NW    = $clog2(MAX_BLOCKS + 1);
   localparam int SWEEP = (MAX_BLOCKS > MAP_WORDS) ? MAX_BLOCKS : MAP_WORDS;
   localparam int SW    = $clog2(SWEEP);
   localparam int BW    = WA + WORD_SHIFT;
   localparam int CW0   = (NW > BW) ? NW : BW;
   localparam int CW    = ((CW0 > COUNT_W) ? CW0 : COUNT_W) + 1;

   // Registers.
   logic [COUNT_W-1:0]   pool_size_ff;
   op_type               op_ff;
   logic [INDEX_W-1:0]   idx_ff;
   logic [WA-1:0]        addr_ff;
   logic [HW-1:0]        hint_ff, hint_in;
   logic [NW-1:0]        used_ff, used_in;
   logic [NW-1:0]        peak_ff, peak_in;
   logic [SW-1:0]        sweep_ff, sweep_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_granted_ff, rsp_granted_in;
   status_type           rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic [WA-1:0]        map_ra, map_wa;
   logic                 map_we;
   logic [WORD_BITS-1:0] map_wd, map_rd;
   logic [BA-1:0]        ref_ra, ref_wa;
   logic                 ref_we;
   logic [REF_WIDTH-1:0] ref_wd, ref_rd;

   // Working values.
   logic [NW-1:0]        pool_clamped;
   logic [WA-1:0]        req_word;
   logic [4:0]           top_pos;
   logic [WORD_BITS-1:0] taken_word;
   logic [BW-1:0]        blk;
   logic                 blk_in_range;
   logic [CW-1:0]        fill_base, fill_count;
   logic [4:0]           fill_rem;
   logic [WORD_BITS-1:0] fill_word;
   logic [NW-1:0]        used_inc;
   logic                 ref_multi;
   logic                 release_blk;
   logic                 respond;

   bba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_addr (map_ra),
      .rd_data (map_rd)
   );

   bba_ram #(.WIDTH(REF_WIDTH), .DEPTH(MAX_BLOCKS)) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_wa),
      .wr_data (ref_wd),
      .rd_addr (ref_ra),
      .rd_data (ref_rd)
   );

   // Pool size clamp and the word and count addresses of the incoming index.
   always_comb begin
      if (CW'(pool_size_ff) > CW'(MAX_BLOCKS)) begin
         pool_clamped = NW'(MAX_BLOCKS);
      end else begin
         pool_clamped = NW'(pool_size_ff);
      end
   end

   assign req_word = WA'(req_block_index >> WORD_SHIFT);
   assign ref_ra   = BA'(req_block_index);

   // The map read address follows the request: hint word for an allocate,
   // the block's word otherwise, then one word per scan step.
   always_comb begin
      priority if (cmd.accept) begin
         map_ra = (op_type'(req_operation) == OP_ALLOC) ? WA'(hint_ff) : req_word;
      end else if (cmd.scan_next) begin
         map_ra = addr_ff + 1'b1;
      end else begin
         map_ra = addr_ff;
      end
   end

   // Highest free block of the word on the read port.
   always_comb begin
      top_pos = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (map_rd[b]) begin
            top_pos = 5'(b);
         end
      end
   end

   assign taken_word   = map_rd & ~(32'd1 << top_pos);
   assign blk          = {addr_ff, top_pos};
   assign blk_in_range = CW'(blk) < CW'(MAX_BLOCKS);

   // Init fill pattern of the map word the sweep counter points at.
   always_comb begin
      fill_base  = CW'(sweep_ff) << WORD_SHIFT;
      fill_count = CW'(pool_clamped);
      fill_rem   = 5'(fill_count - fill_base);
      priority if (fill_count >= CW'(fill_base + CW'(WORD_BITS))) begin
         fill_word = '1;
      end else if (fill_count <= fill_base) begin
         fill_word = '0;
      end else begin
         fill_word = (32'd1 << fill_rem) - 32'd1;
      end
   end

   assign ref_multi   = ref_rd > REF_WIDTH'(1);
   assign release_blk = cmd.rmw_do && (op_ff == OP_FREE) && !ref_multi;
   assign used_inc    = (CW'(used_ff) < CW'(MAX_BLOCKS)) ? used_ff + 1'b1 : used_ff;

   // Memory writes.
   always_comb begin
      map_we = 1'b0;
      map_wa = addr_ff;
      map_wd = '0;
      ref_we = 1'b0;
      ref_wa = BA'(idx_ff);
      ref_wd = '0;
      if (cmd.clear_step) begin
         map_we = CW'(sweep_ff) < CW'(MAP_WORDS);
         map_wa = WA'(sweep_ff);
         ref_we = CW'(sweep_ff) < CW'(MAX_BLOCKS);
         ref_wa = BA'(sweep_ff);
      end
      if (cmd.init_step) begin
         map_we = 1'b1;
         map_wa = WA'(sweep_ff);
         map_wd = fill_word;
      end
      if (cmd.alloc_take) begin
         map_we = 1'b1;
         map_wd = taken_word;
         ref_we = blk_in_range;
         ref_wa = BA'(blk);
         ref_wd = REF_WIDTH'(1);
      end
      if (cmd.rmw_do) begin
         if (op_ff == OP_FREE) begin
            if (ref_multi) begin
               ref_we = 1'b1;
               ref_wd = ref_rd - 1'b1;
            end else begin
               map_we = 1'b1;
               map_wd = map_rd | (32'd1 << idx_ff[WORD_SHIFT-1:0]);
            end
         end else if (ref_rd != '1) begin
            ref_we = 1'b1;
            ref_wd = ref_rd + 1'b1;
         end
      end
   end

   // Hint, counters and response.
   always_comb begin
      hint_in  = hint_ff;
      used_in  = used_ff;
      peak_in  = peak_ff;
      sweep_in = sweep_ff;
      if (cmd.accept) begin
         sweep_in = '0;
      end else if (cmd.clear_step || cmd.init_step) begin
         sweep_in = sweep_ff + 1'b1;
      end
      if (cmd.init_done) begin
         hint_in = '0;
      end
      if (cmd.alloc_take) begin
         hint_in = (taken_word == '0) ? HW'(addr_ff) + 1'b1 : HW'(addr_ff);
         used_in = used_inc;
         peak_in = (used_inc > peak_ff) ? used_inc : peak_ff;
      end
      if (release_blk) begin
         if (HW'(addr_ff) < hint_ff) begin
            hint_in = HW'(addr_ff);
         end
         if (used_ff != '0) begin
            used_in = used_ff - 1'b1;
         end
      end
      respond        = cmd.alloc_take || cmd.alloc_empty || cmd.bad_index ||
                       cmd.rmw_do || cmd.init_done;
      rsp_valid_in   = respond;
      rsp_granted_in = cmd.alloc_take ? INDEX_W'(blk) : '0;
      priority if (cmd.alloc_empty) begin
         rsp_status_in = STAT_EMPTY;
      end else if (cmd.bad_index) begin
         rsp_status_in = STAT_RANGE;
      end else begin
         rsp_status_in = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= POOL_SIZE_RESET;
         hint_ff      <= '0;
         used_ff      <= '0;
         peak_ff      <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            pool_size_ff <= csr_pool_size;
         end
         hint_ff      <= hint_in;
         used_ff      <= used_in;
         peak_ff      <= peak_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= map_ra;
      if (cmd.accept) begin
         op_ff  <= op_type'(req_operation);
         idx_ff <= req_block_index;
      end
      if (respond) begin
         rsp_granted_ff <= rsp_granted_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign stat.sweep_last = sweep_ff == SW'(SWEEP - 1);
   assign stat.init_last  = sweep_ff == SW'(MAP_WORDS - 1);
   assign stat.hint_end   = CW'(hint_ff) >= CW'(MAP_WORDS);
   assign stat.index_ok   = (CW'(req_block_index) < CW'(pool_clamped)) &&
                            (CW'(req_block_index) < CW'(MAX_BLOCKS)) &&
                            (CW'(req_block_index >> WORD_SHIFT) < CW'(MAP_WORDS));
   assign stat.word_zero  = map_rd == '0;
   assign stat.last_word  = addr_ff == WA'(MAP_WORDS - 1);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_used_count    = COUNT_W'(used_ff);
   assign rsp_peak_used     = COUNT_W'(peak_ff);

endmodule

// ===== tb/tb_bitmap_block_allocator_unit.sv =====
// Self-checking testbench for the bitmap block allocator unit.
`timescale 1ns / 1ps

// The bench drives allocator requests through the start/busy handshake,
// predicts every response with its own model of the free map, the word hint,
// the per-block reference counts and the used and peak counters, and checks
// each response strobe against the oldest prediction. A short directed run
// covers the corner cases. It is followed by random phases, one per pool size
// setting, with sender idling that changes from phase to phase.
module tb_bitmap_block_allocator_unit;
   import bba_pkg::*;

   localparam int POOL_BLOCKS = MAX_BLOCKS_DEFAULT;
   localparam int POOL_WORDS  = MAP_WORDS_DEFAULT;
   localparam int PHASES      = 13;
   localparam int RANDOM_PER_PHASE = 95;
   localparam int MAX_REPORTS = 200;

   // One response as the block should present it.
   typedef struct packed {
      logic [INDEX_W-1:0] granted;
      status_type         status;
      logic [COUNT_W-1:0] used;
      logic [COUNT_W-1:0] peak;
   } pool_response_type;

   // Mirror of the allocator state plus the responses still to come.
   class pool_scoreboard_type;
      logic [WORD_BITS-1:0]         free_words [POOL_WORDS];
      logic [REF_WIDTH_DEFAULT-1:0] block_refs [POOL_BLOCKS];
      int unsigned                  hint_word;
      int unsigned                  used_blocks;
      int unsigned                  peak_blocks;
      logic [COUNT_W-1:0]           pool_size;
      logic [INDEX_W-1:0]           live_blocks [$];
      pool_response_type            expected_responses [$];
      int                           errors;

      function new();
         foreach (free_words[w]) free_words[w] = '0;
         foreach (block_refs[b]) block_refs[b] = '0;
         hint_word   = 0;
         used_blocks = 0;
         peak_blocks = 0;
         pool_size   = POOL_SIZE_RESET;
         errors      = 0;
      endfunction

      function pool_response_type predict_response(op_type op, logic [INDEX_W-1:0] idx);
         pool_response_type rsp;
         int unsigned       capacity;
         int unsigned       w;
         int unsigned       b;
         capacity = (pool_size > POOL_BLOCKS) ? POOL_BLOCKS : pool_size;
         rsp.granted = '0;
         rsp.status  = STAT_OK;
         case (op)
            OP_INIT: begin
               foreach (free_words[i]) free_words[i] = '0;
               for (int i = 0; i < capacity; i++)
                  free_words[i / WORD_BITS][i % WORD_BITS] = 1'b1;
               hint_word = 0;
               live_blocks.delete();
            end
            OP_ALLOC: begin
               w = hint_word;
               while (w < POOL_WORDS && free_words[w] == '0)
                  w++;
               if (w >= POOL_WORDS) begin
                  rsp.status = STAT_EMPTY;
               end else begin
                  b = WORD_BITS - 1;
                  while (!free_words[w][b])
                     b--;
                  free_words[w][b] = 1'b0;
                  hint_word = (free_words[w] == '0) ? w + 1 : w;
                  if (used_blocks < POOL_BLOCKS)
                     used_blocks++;
                  if (used_blocks > peak_blocks)
                     peak_blocks = used_blocks;
                  rsp.granted = INDEX_W'(w * WORD_BITS + b);
                  block_refs[rsp.granted] = REF_WIDTH_DEFAULT'(1);
                  live_blocks.push_back(rsp.granted);
               end
            end
            default: begin
               if (idx >= capacity) begin
                  rsp.status = STAT_RANGE;
               end else if (op == OP_FREE) begin
                  if (block_refs[idx] > 1) begin
                     block_refs[idx]--;
                  end else begin
                     w = idx / WORD_BITS;
                     free_words[w][idx % WORD_BITS] = 1'b1;
                     if (w < hint_word)
                        hint_word = w;
                     if (used_blocks > 0)
                        used_blocks--;
                     for (int i = 0; i < live_blocks.size(); i++) begin
                        if (live_blocks[i] == idx) begin
                           live_blocks.delete(i);
                           break;
                        end
                     end
                  end
               end else if (block_refs[idx] != '1) begin
                  block_refs[idx]++;
               end
            end
         endcase
         rsp.used = COUNT_W'(used_blocks);
         rsp.peak = COUNT_W'(peak_blocks);
         return rsp;
      endfunction

      function void note_request(op_type op, logic [INDEX_W-1:0] idx);
         expected_responses.push_back(predict_response(op, idx));
      endfunction

      function void report_mismatch(string field, logic [COUNT_W-1:0] want,
                                    logic [COUNT_W-1:0] got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_response(logic [INDEX_W-1:0] granted, logic [STATUS_W-1:0] status,
                                   logic [COUNT_W-1:0] used, logic [COUNT_W-1:0] peak);
         pool_response_type want;
         if (expected_responses.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response with no request pending, expected none, %s %0d %0d %0d %0d",
                        $time, "actual", granted, status, used, peak);
            return;
         end
         want = expected_responses.pop_front();
         if (granted !== want.granted)
            report_mismatch("granted_index", COUNT_W'(want.granted), COUNT_W'(granted));
         if (status !== want.status)
            report_mismatch("status", COUNT_W'(want.status), COUNT_W'(status));
         if (used !== want.used) report_mismatch("used_count", want.used, used);
         if (peak !== want.peak) report_mismatch("peak_used", want.peak, peak);
      endfunction

      // Mostly blocks that are held, so that frees and retains hit live state.
      function logic [INDEX_W-1:0] pick_block();
         if (live_blocks.size() != 0 && $urandom_range(3) != 0)
            return live_blocks[$urandom_range(live_blocks.size() - 1)];
         return INDEX_W'($urandom_range(POOL_BLOCKS - 1));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation = OP_INIT;
   logic [INDEX_W-1:0]  req_block_index = '0;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_pool_size = POOL_SIZE_RESET;
   logic                rsp_valid;
   logic [INDEX_W-1:0]  rsp_granted_index;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_used_count;
   logic [COUNT_W-1:0]  rsp_peak_used;

   pool_scoreboard_type sb;
   int unsigned         sender_idle_pct = 33;

   bitmap_block_allocator_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_block_index   (req_block_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_pool_size     (csr_pool_size),
      .rsp_valid         (rsp_valid),
      .rsp_granted_index (rsp_granted_index),
      .rsp_status        (rsp_status),
      .rsp_used_count    (rsp_used_count),
      .rsp_peak_used     (rsp_peak_used)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Responses cannot be held off, so every strobe is checked at the edge
   // that ends its cycle. Values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && sb != null)
         sb.check_response(rsp_granted_index, rsp_status, rsp_used_count, rsp_peak_used);
   end

   // Presents one request and returns at the edge that accepts it. The start
   // line stays high into the next request unless the sender decides to idle,
   // so it is assigned at most once per edge.
   task automatic send_request(op_type op, logic [INDEX_W-1:0] idx);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_block_index <= idx;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sb.note_request(op, idx);
   endtask

   // Drops start and waits until every predicted response has been seen and
   // the block reports itself free again.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_responses.size() != 0 || busy)
         @(posedge clock);
   endtask

   // The pool size is only changed while no request is in flight.
   task automatic write_pool_size(logic [COUNT_W-1:0] size);
      wait_idle();
      csr_valid     <= 1'b1;
      csr_pool_size <= size;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid    <= 1'b0;
      sb.pool_size  = size;
   endtask

   function automatic logic [INDEX_W-1:0] any_index();
      return INDEX_W'($urandom_range(POOL_BLOCKS - 1));
   endfunction

   // Hard stop in case the block hangs on a handshake.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int unsigned        pool_choices [PHASES];
      int unsigned        r;
      logic [INDEX_W-1:0] held;
      sb = new();
      pool_choices = '{256, 0, 1, 31, 32, 33, 64, 100, 255, 256, 257, 511, 0};
      pool_choices[PHASES - 1] = $urandom_range(511);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Right after reset no block is free, so an allocate
      // reports an empty pool, and a free of a never-taken block releases it
      // while the used count stays pinned at zero.
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_FREE, 8'd0);
      send_request(OP_ALLOC, 8'hFF);          // takes block 0, hint moves past word 0
      send_request(OP_RETAIN, 8'hFF);
      send_request(OP_INIT, 8'hFF);
      send_request(OP_ALLOC, 8'd0);           // highest bit of word 0 goes first
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_RETAIN, 8'd31);
      send_request(OP_FREE, 8'd31);           // count only drops
      send_request(OP_FREE, 8'd31);           // real release
      send_request(OP_FREE, 8'd31);           // double free releases again
      send_request(OP_FREE, 8'd30);
      send_request(OP_FREE, 8'd30);           // used count saturates at zero
      write_pool_size(9'd0);
      send_request(OP_INIT, 8'd0);
      send_request(OP_ALLOC, 8'd0);           // empty pool
      send_request(OP_FREE, 8'd0);            // index beyond pool size
      send_request(OP_RETAIN, 8'd0);
      write_pool_size(9'd257);                // clamped to the full pool
      send_request(OP_INIT, 8'd0);
      send_request(OP_FREE, 8'hFF);
      send_request(OP_RETAIN, 8'hFF);
      write_pool_size(9'd33);
      send_request(OP_INIT, 8'd0);
      send_request(OP_ALLOC, 8'd0);
      send_request(OP_FREE, 8'd33);           // first index past the pool
      send_request(OP_FREE, 8'd32);

      for (int p = 0; p < PHASES; p++) begin
         // The sender idles often at first, heavily in the middle, and not at
         // all in the last phases.
         if (p < PHASES / 3)
            sender_idle_pct = 33;
         else if (p < 2 * PHASES / 3)
            sender_idle_pct = 80;
         else
            sender_idle_pct = 0;
         write_pool_size(COUNT_W'(pool_choices[p]));
         send_request(OP_INIT, any_index());

         if (p == 0) begin
            // Drain the whole pool so the hint runs off the end, then init
            // again while every block is still held: further allocates must
            // leave the used count stuck at its ceiling.
            repeat (POOL_BLOCKS + 2) send_request(OP_ALLOC, any_index());
            send_request(OP_INIT, any_index());
            repeat (3) send_request(OP_ALLOC, any_index());
         end

         if (p == PHASES - 2) begin
            // Push one block's reference count into saturation, then walk it
            // back down a few steps.
            send_request(OP_ALLOC, any_index());
            held = sb.live_blocks[sb.live_blocks.size() - 1];
            repeat (256) send_request(OP_RETAIN, held);
            repeat (4) send_request(OP_FREE, held);
         end

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            r = $urandom_range(99);
            if (r < 3)
               send_request(OP_INIT, any_index());
            else if (r < 45)
               send_request(OP_ALLOC, any_index());
            else if (r < 82)
               send_request(OP_FREE, sb.pick_block());
            else
               send_request(OP_RETAIN, sb.pick_block());
         end
      end

      // Let the last responses come back, then give the block a little more
      // time in case it answers something extra.
      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.expected_responses.size() != 0)
         sb.errors++;

      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== bitmap_block_allocator_unit.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_datapath.sv
hw/rtl/bitmap_block_allocator_unit.sv
tb/tb_bitmap_block_allocator_unit.sv
